// File: hw/rtl/itda_pkg.sv
// shared constants and types for the integer to decimal ascii block
package itda_pkg;

   // width of the signed input word, sign in the top bit
   localparam int VALUE_BITS = 32;
   // binary bits taken into the digit row per conversion cycle
   localparam int STEP_BITS = 4;
   localparam int CONV_STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int SHIFT_BITS = CONV_STEPS * STEP_BITS;
   // decimal digits of 2^(VALUE_BITS-1); 1233/4096 is just under log10(2)
   localparam int DIGITS = (((VALUE_BITS - 1) * 1233) >> 12) + 1;
   localparam int CONV_CNT_BITS = $clog2(CONV_STEPS);
   localparam int DIGIT_CNT_BITS = $clog2(DIGITS + 1);

   // ascii codes as carried on the 6-bit character port
   localparam int CODE_BITS = 6;
   localparam logic [CODE_BITS-1:0] ZERO_CODE = 6'd48;
   localparam logic [CODE_BITS-1:0] MINUS_CODE = 6'd45;
   localparam logic [3:0] ADJUST_LIMIT = 4'd5;
   localparam logic [3:0] ADJUST_ADD = 4'd3;

   typedef logic [3:0] digit_type;

   // per-cycle command to every cell of the digit row
   typedef struct packed {
      logic load;
      logic convert;
      logic shift;
   } cell_ctrl_type;

endpackage

// File: hw/rtl/itda_cell.sv
// one bcd digit cell of the double-dabble row, also shifts digits out toward the top
module itda_cell (
   input  logic                                clock,
   input  itda_pkg::cell_ctrl_type             ctrl,
   input  logic [itda_pkg::STEP_BITS-1:0]      carry_in,
   input  itda_pkg::digit_type                 lower_digit,
   output logic [itda_pkg::STEP_BITS-1:0]      carry_out,
   output itda_pkg::digit_type                 digit
);

   itda_pkg::digit_type digit_ff;
   itda_pkg::digit_type digit_in;
   itda_pkg::digit_type step_digit [itda_pkg::STEP_BITS+1];
   itda_pkg::digit_type adj_digit [itda_pkg::STEP_BITS];

   // add-3 then shift, once per binary bit taken this cycle
   always_comb begin
      step_digit[0] = digit_ff;
      for (int k = 0; k < itda_pkg::STEP_BITS; k++) begin
         if (step_digit[k] >= itda_pkg::ADJUST_LIMIT) begin
            adj_digit[k] = 4'(step_digit[k] + itda_pkg::ADJUST_ADD);
         end else begin
            adj_digit[k] = step_digit[k];
         end
         carry_out[k] = adj_digit[k][3];
         step_digit[k+1] = {adj_digit[k][2:0], carry_in[k]};
      end
   end

   // next digit: clear, convert, take the lower neighbor's digit, or hold
   always_comb begin
      if (ctrl.load) begin
         digit_in = '0;
      end else if (ctrl.convert) begin
         digit_in = step_digit[itda_pkg::STEP_BITS];
      end else if (ctrl.shift) begin
         digit_in = lower_digit;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

// File: hw/rtl/integer_to_decimal_ascii.sv
// top level: signed integer to decimal ascii text, one character word per handshake
// flow: a taken input word is loaded in idle and converted in the conversion state; then
// a minus sign for a negative value and the digits are offered, leading zeros skipped first
// a new input word is taken only after the last digit of the previous one is accepted;
// one word in flight
// reset: synchronous, active high, returns the controller to idle; digit cells need none
module integer_to_decimal_ascii (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [itda_pkg::VALUE_BITS-1:0]      req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [itda_pkg::CODE_BITS-1:0]       rsp_char_code,
   output logic                                 rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type                              state_ff, state_in;
   logic [itda_pkg::SHIFT_BITS-1:0]        mag_ff, mag_in;
   logic                                   neg_ff, neg_in;
   logic                                   started_ff, started_in;
   logic [itda_pkg::CONV_CNT_BITS-1:0]     conv_cnt_ff, conv_cnt_in;
   logic [itda_pkg::DIGIT_CNT_BITS-1:0]    rem_ff, rem_in;

   itda_pkg::cell_ctrl_type                cell_ctrl;
   itda_pkg::digit_type                    digit_chain [itda_pkg::DIGITS+1];
   logic [itda_pkg::STEP_BITS-1:0]         carry_chain [itda_pkg::DIGITS+1];
   logic [itda_pkg::VALUE_BITS-1:0]        abs_value;
   itda_pkg::digit_type                    top_digit;
   logic                                   skip;
   logic                                   rsp_accept;

   // magnitude formed unsigned, so the most negative value stays correct
   assign abs_value = req_value[itda_pkg::VALUE_BITS-1] ?
                      (~req_value) + itda_pkg::VALUE_BITS'(1) : req_value;

   // bottom of the row: magnitude bits msb first, zeros shifted in during output
   assign digit_chain[0] = '0;
   for (genvar k = 0; k < itda_pkg::STEP_BITS; k++) begin : g_feed
      assign carry_chain[0][k] = mag_ff[itda_pkg::SHIFT_BITS-1-k];
   end

   // row of digit cells, least significant at the bottom
   for (genvar i = 0; i < itda_pkg::DIGITS; i++) begin : g_cell
      itda_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .carry_in    (carry_chain[i]),
         .lower_digit (digit_chain[i]),
         .carry_out   (carry_chain[i+1]),
         .digit       (digit_chain[i+1])
      );
   end

   assign top_digit = digit_chain[itda_pkg::DIGITS];

   // leading zeros are dropped without a word, the final digit is always sent
   assign skip = !started_ff && (top_digit == '0) &&
                 (rem_ff > itda_pkg::DIGIT_CNT_BITS'(1));

   // output port, driven from registers only
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_SIGN) || ((state_ff == ST_EMIT) && !skip);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign rsp_char_code = (state_ff == ST_SIGN) ? itda_pkg::MINUS_CODE :
                          itda_pkg::CODE_BITS'(itda_pkg::ZERO_CODE +
                                               itda_pkg::CODE_BITS'(top_digit));
   assign rsp_last = (state_ff == ST_EMIT) && (rem_ff == itda_pkg::DIGIT_CNT_BITS'(1));

   // controller next state
   always_comb begin
      state_in = state_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      started_in = started_ff;
      conv_cnt_in = conv_cnt_ff;
      rem_in = rem_ff;
      cell_ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cell_ctrl.load = 1'b1;
               mag_in = itda_pkg::SHIFT_BITS'(abs_value);
               neg_in = req_value[itda_pkg::VALUE_BITS-1];
               conv_cnt_in = itda_pkg::CONV_CNT_BITS'(itda_pkg::CONV_STEPS - 1);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cell_ctrl.convert = 1'b1;
            mag_in = mag_ff << itda_pkg::STEP_BITS;
            if (conv_cnt_ff == '0) begin
               rem_in = itda_pkg::DIGIT_CNT_BITS'(itda_pkg::DIGITS);
               started_in = 1'b0;
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end else begin
               conv_cnt_in = itda_pkg::CONV_CNT_BITS'(conv_cnt_ff - 1'b1);
            end
         end
         ST_SIGN: begin
            // leading zeros drain while the minus sign waits
            if (skip) begin
               cell_ctrl.shift = 1'b1;
               rem_in = itda_pkg::DIGIT_CNT_BITS'(rem_ff - 1'b1);
            end
            if (rsp_accept) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (skip) begin
               cell_ctrl.shift = 1'b1;
               rem_in = itda_pkg::DIGIT_CNT_BITS'(rem_ff - 1'b1);
            end else if (rsp_accept) begin
               cell_ctrl.shift = 1'b1;
               rem_in = itda_pkg::DIGIT_CNT_BITS'(rem_ff - 1'b1);
               started_in = 1'b1;
               if (rem_ff == itda_pkg::DIGIT_CNT_BITS'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // controller registers
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         started_ff <= 1'b0;
         conv_cnt_ff <= '0;
         rem_ff <= '0;
      end else begin
         state_ff <= state_in;
         started_ff <= started_in;
         conv_cnt_ff <= conv_cnt_in;
         rem_ff <= rem_in;
      end
   end

   // the magnitude always fits the digit row
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> (carry_chain[itda_pkg::DIGITS] == '0))
      else $error("digit row overflow during conversion");

   // every digit word is a decimal digit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (state_ff == ST_EMIT)) |->
      ((rsp_char_code >= itda_pkg::ZERO_CODE) &&
       (rsp_char_code <= itda_pkg::CODE_BITS'(itda_pkg::ZERO_CODE + 6'd9))))
      else $error("digit word outside 0 to 9");

   // the last word of a number ends the item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last) |=> (state_ff == ST_IDLE))
      else $error("controller busy after last word");

   // a taken input word starts conversion
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CONV))
      else $error("conversion not started");

   // output never runs past the digit count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rem_ff != '0))
      else $error("digit count exhausted while emitting");

endmodule
